// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the reassembler RTL.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("reassembler check failed");
`define RFR_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("reassembler forbidden condition seen");
`else
`define RFR_ASSERT(lbl, prop)
`define RFR_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/rfr_pkg.sv =====
`default_nettype none

package rfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 512;
    localparam int HEADER_BYTES    = 12;
    localparam int HDR_KEEP        = 10;
    localparam logic [9:0]  WCNT_MAX        = 10'd1023;
    localparam logic [7:0]  MAGIC_0         = 8'h4C;
    localparam logic [7:0]  MAGIC_1         = 8'h52;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd2000;
    localparam logic [7:0]  VERSION_RESET   = 8'd1;
    localparam logic [31:0] SEQ_MAX         = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DISC  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNSUP   = 3'd1,
        ST_BAD_LEN = 3'd2,
        ST_BAD_VAL = 3'd3,
        ST_NO_RES  = 3'd4
    } status_t;

    typedef enum logic [7:0] {
        REG_TIMEOUT = 8'd0,
        REG_VERSION = 8'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        SINK_OK    = 2'd0,
        SINK_NOMEM = 2'd1
    } sink_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  conn_id;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [9:0]  write_len;
        logic        unsupported_write;
        logic [31:0] now_ms;
        logic [1:0]  sink_status;
        logic [8:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  accepted_len;
        logic        deliver;
        logic        duplicate;
        logic [9:0]  message_len;
        logic [7:0]  read_data;
        logic [31:0] expected_sequence;
    } out_item_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  conn_id;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [9:0]  write_len;
        logic        unsupported_write;
        logic [31:0] now_ms;
        logic [1:0]  sink_status;
        logic [8:0]  read_index;
    } cmd_t;

    function automatic logic [31:0] seq_after(input logic [31:0] s);
        return (s == SEQ_MAX) ? 32'd1 : s + 32'd1;
    endfunction

    function automatic logic [31:0] seq_before(input logic [31:0] s);
        return (s == 32'd1) ? SEQ_MAX : s - 32'd1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/reliable_frame_reassembler.sv =====
// Reliable frame reassembler.
//
// Input channel (in_valid, in_stall, in_data) carries one item per transfer:
// a byte of a link write, a payload read and status query, or a disconnect.
// The first write of a message opens with a 12-byte header that is checked
// before its payload bytes go into the payload store.
// Output channel (out_valid, out_stall, out_data) carries one result transfer
// for the last byte of each write and for each read query; other items give
// no result.
// An input transfer passes through the two-entry queue of the front part and
// then the back part, whose result register and registered store read appear
// together.
// Throughput is one item per cycle; the back part retires one queued item in
// each cycle in which its result register is empty or being taken.
// While out_stall is high with a result waiting, the back part holds and the
// queue fills; in_stall rises once both queue entries are occupied.
// Reset clears the queue, all message state and the expected sequence
// (back to 1); the timeout and version registers return to 2000 ms and 1.
// The payload store is not cleared, and no pass over it is needed.
// Configuration (cfg_we, cfg_index, cfg_data): the user writes it only while idle; the block does not check this.
`default_nettype none

module reliable_frame_reassembler
    import rfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic [7:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    logic q_valid;
    logic pop;
    cmd_t q_head;

    // Front part: classifies items and queues them.
    rfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data (in_data),
        .pop     (pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    // Back part: message state, payload store and result register.
    rfr_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/rfr_ram.sv =====
`default_nettype none

module rfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/rfr_front.sv =====
`default_nettype none

`include "assert_macros.svh"

module rfr_front
    import rfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    input  wire logic     pop,
    output logic          q_valid,
    output cmd_t          q_head
);

    // Two-entry queue between the front and the back part.
    cmd_t       slot_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, keep;
    cmd_t       cmd;

    // Items of the unused kind are accepted and dropped here.
    always_comb
    begin
        cmd.kind              = kind_t'(in_data.kind);
        cmd.conn_id           = in_data.conn_id;
        cmd.data_byte         = in_data.data_byte;
        cmd.first_byte        = in_data.first_byte;
        cmd.last_byte         = in_data.last_byte;
        cmd.write_len         = in_data.write_len;
        cmd.unsupported_write = in_data.unsupported_write;
        cmd.now_ms            = in_data.now_ms;
        cmd.sink_status       = in_data.sink_status;
        cmd.read_index        = in_data.read_index;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign keep     = push && (cmd.kind != KIND_NONE);
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ keep;
        count_next  = count_reg + {1'b0, keep} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            slot_reg[wr_ptr_reg] <= cmd;
        end
    end

    `RFR_NEVER(a_count_range, count_reg == 2'd3)
    `RFR_NEVER(a_pop_empty, pop && !q_valid)
    `RFR_ASSERT(a_ptr_count, (count_reg == 2'd1) |-> (rd_ptr_reg != wr_ptr_reg))

endmodule

`default_nettype wire

// ===== rtl/rfr_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module rfr_back
    import rfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic       q_valid,
    input  wire cmd_t       q_head,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data
);

    localparam int AW    = $clog2(MAX_PAYLOAD);
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CW    = (LEN_W > 10) ? LEN_W : 10;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

    logic [15:0]      timeout_reg;
    logic [7:0]       version_reg;
    logic [9:0]       wcnt_reg, wcnt_next;
    logic [LEN_W-1:0] exp_reg, exp_next;
    logic [LEN_W-1:0] rcv_reg, rcv_next;
    logic [31:0]      mseq_reg, mseq_next;
    logic [7:0]       mconn_reg, mconn_next;
    logic [31:0]      start_reg, start_next;
    logic [31:0]      nseq_reg, nseq_next;
    logic [2:0]       err_reg, err_next;
    logic             active_reg, active_next;
    logic             ishdr_reg, ishdr_next;
    logic [7:0]       hdr_reg [HDR_KEEP];
    logic [7:0]       hdr_next [HDR_KEEP];

    logic             ovalid_reg, ovalid_next;
    out_item_t        oitem_reg, oitem_next;
    logic             ordsel_reg, ordsel_next;

    logic             res_valid, rd_sel, ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_q;
    logic [9:0]       idx;
    logic [31:0]      age, seq_hdr;
    logic [15:0]      plen;
    logic [9:0]       frag;
    logic             load_out;

    assign load_out = !ovalid_reg || !out_stall;
    assign pop      = q_valid && load_out;
    assign ram_re   = pop && (q_head.kind == KIND_READ);

    always_comb
    begin
        wcnt_next   = wcnt_reg;
        exp_next    = exp_reg;
        rcv_next    = rcv_reg;
        mseq_next   = mseq_reg;
        mconn_next  = mconn_reg;
        start_next  = start_reg;
        nseq_next   = nseq_reg;
        err_next    = err_reg;
        active_next = active_reg;
        ishdr_next  = ishdr_reg;
        for (int i = 0; i < HDR_KEEP; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        res_valid  = 1'b0;
        rd_sel     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = rcv_reg[AW-1:0];
        idx        = wcnt_reg;
        age        = q_head.now_ms - start_reg;
        seq_hdr    = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
        plen       = {hdr_reg[9], hdr_reg[8]};
        frag       = q_head.write_len - 10'(HEADER_BYTES);
        oitem_next = '0;

        if (pop)
        begin
            case (q_head.kind)
                KIND_DISC:
                begin
                    if (exp_reg != '0 && mconn_reg == q_head.conn_id)
                    begin
                        exp_next   = '0;
                        rcv_next   = '0;
                        mseq_next  = '0;
                        mconn_next = '0;
                        start_next = '0;
                    end
                end
                KIND_READ:
                begin
                    res_valid              = 1'b1;
                    rd_sel                 = (32'(q_head.read_index) < 32'(MAX_PAYLOAD));
                    oitem_next.message_len = 10'(rcv_reg);
                end
                KIND_WRITE:
                begin
                    if (q_head.first_byte)
                    begin
                        active_next = 1'b1;
                        wcnt_next   = '0;
                        err_next    = ST_OK;
                        ishdr_next  = 1'b0;
                        if (q_head.unsupported_write)
                        begin
                            err_next = ST_UNSUP;
                        end
                        else
                        begin
                            if (exp_reg != '0 && age > {16'd0, timeout_reg})
                            begin
                                exp_next   = '0;
                                rcv_next   = '0;
                                mseq_next  = '0;
                                mconn_next = '0;
                                start_next = '0;
                            end
                            if (exp_next == '0)
                            begin
                                ishdr_next = 1'b1;
                                start_next = q_head.now_ms;
                                mconn_next = q_head.conn_id;
                                if (q_head.write_len < 10'(HEADER_BYTES))
                                begin
                                    err_next = ST_BAD_LEN;
                                end
                            end
                            else if (q_head.conn_id != mconn_reg ||
                                     CW'(q_head.write_len) > CW'(exp_reg - rcv_reg))
                            begin
                                exp_next   = '0;
                                rcv_next   = '0;
                                mseq_next  = '0;
                                mconn_next = '0;
                                start_next = '0;
                                err_next   = ST_BAD_VAL;
                            end
                        end
                    end

                    if (active_next)
                    begin
                        idx = wcnt_next;
                        if (wcnt_next < WCNT_MAX)
                        begin
                            wcnt_next = wcnt_next + 10'd1;
                        end
                        if (err_next == ST_OK)
                        begin
                            if (ishdr_next && idx < 10'(HEADER_BYTES))
                            begin
                                for (int i = 0; i < HDR_KEEP; i++)
                                begin
                                    if (idx == 10'(i))
                                    begin
                                        hdr_next[i] = q_head.data_byte;
                                    end
                                end
                                if (idx == 10'(HEADER_BYTES - 1))
                                begin
                                    if (q_head.write_len < 10'(HEADER_BYTES))
                                    begin
                                        err_next = ST_BAD_LEN;
                                    end
                                    else if (hdr_reg[0] != MAGIC_0 ||
                                             hdr_reg[1] != MAGIC_1 ||
                                             hdr_reg[2] != version_reg ||
                                             plen == 16'd0 ||
                                             plen > 16'(MAX_PAYLOAD) ||
                                             16'(frag) > plen)
                                    begin
                                        err_next = ST_BAD_VAL;
                                    end
                                    else
                                    begin
                                        mseq_next = seq_hdr;
                                        exp_next  = LEN_W'(plen);
                                        rcv_next  = '0;
                                    end
                                end
                            end
                            else if (exp_next != '0 && rcv_next < exp_next &&
                                     rcv_next < LEN_MAX)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = rcv_next[AW-1:0];
                                rcv_next  = rcv_next + 1'b1;
                            end
                        end

                        if (q_head.last_byte)
                        begin
                            active_next       = 1'b0;
                            res_valid         = 1'b1;
                            oitem_next.status = ST_OK;
                            if (err_next != ST_OK)
                            begin
                                oitem_next.status = err_next;
                            end
                            else if (ishdr_next && wcnt_next < 10'(HEADER_BYTES))
                            begin
                                oitem_next.status = ST_BAD_LEN;
                            end
                            else if (exp_next != '0 && rcv_next == exp_next)
                            begin
                                oitem_next.message_len = 10'(exp_next);
                                if (mseq_next == nseq_reg)
                                begin
                                    oitem_next.deliver = 1'b1;
                                    if (q_head.sink_status == SINK_OK)
                                    begin
                                        nseq_next = seq_after(nseq_reg);
                                    end
                                    else if (q_head.sink_status == SINK_NOMEM)
                                    begin
                                        oitem_next.status = ST_NO_RES;
                                    end
                                    else
                                    begin
                                        oitem_next.status = ST_BAD_VAL;
                                    end
                                end
                                else if (mseq_next != seq_before(nseq_reg))
                                begin
                                    oitem_next.status = ST_BAD_VAL;
                                end
                                else
                                begin
                                    oitem_next.duplicate = 1'b1;
                                end
                                exp_next   = '0;
                                rcv_next   = '0;
                                mseq_next  = '0;
                                mconn_next = '0;
                                start_next = '0;
                            end
                            if (oitem_next.status == ST_OK)
                            begin
                                oitem_next.accepted_len = q_head.write_len;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        oitem_next.expected_sequence = nseq_next;
        ovalid_next = load_out ? res_valid : ovalid_reg;
        ordsel_next = rd_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            version_reg <= VERSION_RESET;
            wcnt_reg    <= '0;
            exp_reg     <= '0;
            rcv_reg     <= '0;
            mseq_reg    <= '0;
            mconn_reg   <= '0;
            start_reg   <= '0;
            nseq_reg    <= 32'd1;
            err_reg     <= '0;
            active_reg  <= 1'b0;
            ishdr_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
            for (int i = 0; i < HDR_KEEP; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_VERSION)
            begin
                version_reg <= cfg_data[7:0];
            end
            wcnt_reg   <= wcnt_next;
            exp_reg    <= exp_next;
            rcv_reg    <= rcv_next;
            mseq_reg   <= mseq_next;
            mconn_reg  <= mconn_next;
            start_reg  <= start_next;
            nseq_reg   <= nseq_next;
            err_reg    <= err_next;
            active_reg <= active_next;
            ishdr_reg  <= ishdr_next;
            ovalid_reg <= ovalid_next;
            for (int i = 0; i < HDR_KEEP; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            oitem_reg  <= oitem_next;
            ordsel_reg <= ordsel_next;
        end
    end

    rfr_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(q_head.data_byte),
        .re   (ram_re),
        .raddr(AW'(q_head.read_index)),
        .rdata(ram_q)
    );

    always_comb
    begin
        out_data           = oitem_reg;
        out_data.read_data = ordsel_reg ? ram_q : 8'd0;
    end
    assign out_valid = ovalid_reg;

    `RFR_ASSERT(a_rcv_le_exp, (exp_reg != '0) |-> (rcv_reg <= exp_reg))
    `RFR_ASSERT(a_idle_empty, (exp_reg == '0) |-> (rcv_reg == '0))
    `RFR_NEVER(a_seq_zero, nseq_reg == 32'd0)
    `RFR_ASSERT(a_read_hold, (ovalid_reg && out_stall && ordsel_reg) |=> $stable(ram_q))

endmodule

`default_nettype wire
